// ----- sv/vlhe_pkg.sv -----
// ----------------------------------------------------------------------------
// vlhe_pkg
// Shared constants and elaboration-time helpers for the variable-length
// Hamming encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vlhe_pkg;

  // Default number of data word bits that take part in the message.
  localparam int DATA_WIDTH_DEF = 26;

  // Fixed widths of the result fields.
  localparam int CODEWORD_W   = 31;
  localparam int PARITY_W     = 6;
  localparam int MSG_LEN_W    = 5;
  localparam int PAR_COUNT_W  = 3;
  localparam int CW_LEN_W     = 5;

  // Fewest parity bits r with 2^r >= width + r + 1 for the longest message.
  function automatic int parity_bits_for(input int width);
    int r;
    r = 1;
    for (int i = 0; i < 16; i++) begin
      if ((1 << r) < width + r + 1) begin
        r = r + 1;
      end
    end
    return r;
  endfunction

  // True for a codeword position that carries a parity bit.
  function automatic bit is_pow2(input int p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // Message bit index held at a data position: positions below p that are
  // powers of two are skipped.
  function automatic int msg_index(input int p);
    int cnt;
    cnt = 0;
    for (int t = 0; t < 31; t++) begin
      if ((1 << t) <= p) begin
        cnt = cnt + 1;
      end
    end
    return p - 1 - cnt;
  endfunction

endpackage

// ----- sv/vlhe_encode.sv -----
// ----------------------------------------------------------------------------
// vlhe_encode
// Combinational encoder: finds the message length and parity count, places
// the message bits at the data positions, computes the parity trees and
// right-aligns the codeword and the parity field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vlhe_encode
  import vlhe_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int R_MAX      = parity_bits_for(DATA_WIDTH),
  parameter int CW_MAX     = DATA_WIDTH + R_MAX,
  parameter int M_W        = $clog2(DATA_WIDTH + 1),
  parameter int R_W        = $clog2(R_MAX + 1),
  parameter int N_W        = $clog2(CW_MAX + 1)
) (
  input  logic [DATA_WIDTH-1:0] word,
  output logic [CW_MAX-1:0]     codeword,
  output logic [R_MAX-1:0]      parity,
  output logic [M_W-1:0]        msg_len,
  output logic [R_W-1:0]        par_cnt,
  output logic [N_W-1:0]        cw_len
);

  logic [DATA_WIDTH-1:0] aligned;
  logic [CW_MAX:1]       data_pos;
  logic [CW_MAX:1]       full_pos;
  logic [CW_MAX-1:0]     msb_first;
  logic [R_MAX-1:0]      par_bits;
  logic [R_MAX-1:0]      par_rev;

  // Message length: leading one position plus one, at least one.
  always_comb begin
    msg_len = M_W'(1);
    for (int k = 0; k < DATA_WIDTH; k++) begin
      if (word[k]) begin
        msg_len = M_W'(k + 1);
      end
    end
  end

  // Fewest parity bits that cover the message; candidates are independent.
  always_comb begin
    par_cnt = R_W'(R_MAX);
    for (int rr = R_MAX; rr >= 1; rr--) begin
      if ((1 << rr) >= int'(msg_len) + rr + 1) begin
        par_cnt = R_W'(rr);
      end
    end
  end

  assign cw_len = N_W'(msg_len) + N_W'(par_cnt);

  // Left-align the message so its first bit sits at the top.
  assign aligned = word << (M_W'(DATA_WIDTH) - msg_len);

  // Data positions take message bits in order; parity positions start clear.
  for (genvar p = 1; p <= CW_MAX; p++) begin : g_data
    if (is_pow2(p)) begin : g_par_slot
      assign data_pos[p] = 1'b0;
    end else begin : g_data_slot
      assign data_pos[p] = aligned[DATA_WIDTH-1-msg_index(p)];
    end
  end

  // Even parity trees; positions past the codeword end hold zero.
  for (genvar t = 0; t < R_MAX; t++) begin : g_parity
    logic acc;
    always_comb begin
      acc = 1'b0;
      for (int p = 1; p <= CW_MAX; p++) begin
        if (((p >> t) & 1) == 1 && !is_pow2(p)) begin
          acc = acc ^ data_pos[p];
        end
      end
    end
    assign par_bits[t]            = acc;
    assign par_rev[R_MAX-1-t]     = acc;
  end

  // Merge parity bits into their positions and order position one first.
  for (genvar p = 1; p <= CW_MAX; p++) begin : g_merge
    if (is_pow2(p)) begin : g_par_slot
      assign full_pos[p] = par_bits[$clog2(p)];
    end else begin : g_data_slot
      assign full_pos[p] = data_pos[p];
    end
    assign msb_first[CW_MAX-p] = full_pos[p];
  end

  // Right-align to the actual codeword and parity lengths.
  assign codeword = msb_first >> (N_W'(CW_MAX) - cw_len);
  assign parity   = par_rev >> (R_W'(R_MAX) - par_cnt);

endmodule

// ----- sv/variable_length_hamming_encoder.sv -----
// ----------------------------------------------------------------------------
// variable_length_hamming_encoder
// Even-parity Hamming encoder whose codeword length follows the position of
// the leading one in the data word.
// A request is captured in the input register, encoded by the combinational
// encoder and captured in the result register, which drives the out_ ports
// with out_strobe high.
// Throughput: one request per cycle; busy stays low, since the input
// register and result register are parted by a single combinational encoder.
// Reset clears the valid flags only; the receiver cannot stall results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module variable_length_hamming_encoder
  import vlhe_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [DATA_WIDTH-1:0]  in_data_word,
  output logic                   out_strobe,
  output logic [CODEWORD_W-1:0]  out_codeword,
  output logic [PARITY_W-1:0]    out_parity_value,
  output logic [MSG_LEN_W-1:0]   out_message_length,
  output logic [PAR_COUNT_W-1:0] out_parity_count,
  output logic [CW_LEN_W-1:0]    out_codeword_length
);

  localparam int R_MAX  = parity_bits_for(DATA_WIDTH);
  localparam int CW_MAX = DATA_WIDTH + R_MAX;
  localparam int M_W    = $clog2(DATA_WIDTH + 1);
  localparam int R_W    = $clog2(R_MAX + 1);
  localparam int N_W    = $clog2(CW_MAX + 1);

  logic                  req_valid_r;
  logic [DATA_WIDTH-1:0] req_word_r;
  logic [CW_MAX-1:0]     enc_codeword;
  logic [R_MAX-1:0]      enc_parity;
  logic [M_W-1:0]        enc_msg_len;
  logic [R_W-1:0]        enc_par_cnt;
  logic [N_W-1:0]        enc_cw_len;

  logic                   out_strobe_r;
  logic [CODEWORD_W-1:0]  out_codeword_r;
  logic [PARITY_W-1:0]    out_parity_value_r;
  logic [MSG_LEN_W-1:0]   out_message_length_r;
  logic [PAR_COUNT_W-1:0] out_parity_count_r;
  logic [CW_LEN_W-1:0]    out_codeword_length_r;

  // A new request is taken in every cycle.
  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= start && !busy;
    end
    if (start && !busy) begin
      req_word_r <= in_data_word;
    end
  end

  // Encoder between the two registers.
  vlhe_encode #(
    .DATA_WIDTH (DATA_WIDTH),
    .R_MAX      (R_MAX),
    .CW_MAX     (CW_MAX),
    .M_W        (M_W),
    .R_W        (R_W),
    .N_W        (N_W)
  ) u_encode (
    .word     (req_word_r),
    .codeword (enc_codeword),
    .parity   (enc_parity),
    .msg_len  (enc_msg_len),
    .par_cnt  (enc_par_cnt),
    .cw_len   (enc_cw_len)
  );

  // Result register, fields cut or extended to their port widths.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= req_valid_r;
    end
    if (req_valid_r) begin
      out_codeword_r        <= CODEWORD_W'(enc_codeword);
      out_parity_value_r    <= PARITY_W'(enc_parity);
      out_message_length_r  <= MSG_LEN_W'(enc_msg_len);
      out_parity_count_r    <= PAR_COUNT_W'(enc_par_cnt);
      out_codeword_length_r <= CW_LEN_W'(enc_cw_len);
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_codeword        = out_codeword_r;
  assign out_parity_value    = out_parity_value_r;
  assign out_message_length  = out_message_length_r;
  assign out_parity_count    = out_parity_count_r;
  assign out_codeword_length = out_codeword_length_r;

  // Every accepted request reaches the input register.
  a_req_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> req_valid_r)
    else $error("accepted request did not reach the input register");

  // Every registered request gives exactly one strobe in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe == $past(req_valid_r))
    else $error("result strobe does not follow the input register");

  // Codeword length is the message length plus the parity count.
  a_len_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_codeword_length ==
                    CW_LEN_W'(out_message_length) + CW_LEN_W'(out_parity_count)))
    else $error("codeword length mismatch");

  // At least two parity bits are always used.
  a_min_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_parity_count >= PAR_COUNT_W'(2)))
    else $error("parity count below two");

endmodule
